// ===== hw/rtl/klt_pkg.sv =====
package klt_pkg;

  localparam int KEY_W  = 31;
  localparam int PAY_W  = 64;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 6;
  localparam int CFG_W  = 6;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_STRATEGY = 1'b1;

  localparam logic [CFG_W-1:0] CAP_RESET   = 6'd30;
  localparam logic             STRAT_RESET = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [KEY_W-1:0]  found_key;
    logic [PAY_W-1:0]  found_payload;
    logic [CNT_W-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic append;
    logic read_pos;
    logic res_empty;
    logic cap_read;
    logic scan_init;
    logic scan_step;
    logic cap_hit;
    logic res_miss;
    logic shift_init;
    logic shift_step;
    logic move_rd;
    logic move_wr;
    logic dec_count;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              strategy;
    logic              pos_ok;
    logic              match;
    logic              scan_done;
  } sts_t;

endpackage

// ===== hw/rtl/keyed_list_table_top.sv =====
// Keyed list table: an unsorted list of up to MAX_ENTRIES records (key plus
// 64-bit payload), searched linearly.
// Input channel (in_valid_i / in_ready_o / in_word_i): one word per command,
// mode = append, lookup, remove or read position. Output channel
// (out_valid_o / out_ready_i / out_word_o): exactly one result word per
// command, in order. Config port: cfg_we_i writes cfg_data_i to register
// cfg_idx_i (0 capacity limit, 1 remove strategy) with no handshake.
// One command is in flight at a time; a new word is taken the cycle after the
// previous result is loaded into the output register.
// Append and a read of an empty position finish in S_EXEC; any other read goes
// through S_READ to capture the registered store output. Lookup and remove
// scan the list from position 0, one entry per cycle through the registered
// read port of the store, and stop at the first match or at the fill count.
// Remove then moves the last entry into the hole (strategy 0) or shifts every
// later entry down one place (strategy 1), again one entry per cycle.
// Reset empties the list and sets capacity 30, shift removal; the store is
// not cleared. A stalled output holds its word; the next result waits in the
// controller and the input stays not ready until the output register is free.
module keyed_list_table_top #(
  parameter int MAX_ENTRIES = 32,
  parameter int KEY_BITS    = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  klt_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output klt_pkg::out_word_t        out_word_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [klt_pkg::CFG_W-1:0] cfg_data_i
);

  klt_pkg::cmd_t cmd;
  klt_pkg::sts_t sts;

  klt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  klt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

// ===== hw/rtl/klt_datapath.sv =====
module klt_datapath #(
  parameter int MAX_ENTRIES = 32,
  parameter int KEY_BITS    = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  klt_pkg::in_word_t       in_word_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [klt_pkg::CFG_W-1:0] cfg_data_i,
  input  klt_pkg::cmd_t           cmd_i,
  output klt_pkg::sts_t           sts_o,
  output klt_pkg::out_word_t      out_word_o
);

  localparam int IdxW  = $clog2(MAX_ENTRIES);
  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int WideW = (CntW > klt_pkg::CNT_W) ? CntW : klt_pkg::CNT_W;
  localparam int EntW  = KEY_BITS + klt_pkg::PAY_W;

  logic [EntW-1:0] mem [MAX_ENTRIES];

  klt_pkg::in_word_t item_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [klt_pkg::CFG_W-1:0] cap_q;
  logic              strat_q;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              rdv_q, rdv_d;
  logic [IdxW-1:0]   cmp_idx_q;
  logic [IdxW-1:0]   found_idx_q;
  logic [EntW-1:0]   rd_q;

  logic [klt_pkg::STAT_W-1:0] res_status_q;
  logic [klt_pkg::POS_W-1:0]  res_pos_q;
  logic [KEY_BITS-1:0]        res_key_q;
  logic [klt_pkg::PAY_W-1:0]  res_pay_q;
  klt_pkg::out_word_t         out_q;

  logic [63:0]               item_key_wide;
  logic [KEY_BITS-1:0]       item_key;
  logic [KEY_BITS-1:0]       rd_key;
  logic [klt_pkg::PAY_W-1:0] rd_pay;
  logic                      full;
  logic                      ptr_lt;
  logic                      step;
  logic [IdxW-1:0]           pos_idx;
  logic [IdxW-1:0]           last_idx;
  logic [31:0]               count_w32;
  logic [31:0]               cmp_w32;
  logic [WideW-1:0]          count_wide;
  logic [63:0]               res_key_wide;

  logic                      rd_en;
  logic [IdxW-1:0]           rd_addr;
  logic                      wr_en;
  logic [IdxW-1:0]           wr_addr;
  logic [EntW-1:0]           wr_data;

  assign item_key_wide = 64'(item_q.key);
  assign item_key      = item_key_wide[KEY_BITS-1:0];
  assign rd_key        = rd_q[EntW-1:klt_pkg::PAY_W];
  assign rd_pay        = rd_q[klt_pkg::PAY_W-1:0];
  assign full          = (WideW'(count_q) >= WideW'(cap_q)) ||
                         (count_q == CntW'(MAX_ENTRIES));
  assign ptr_lt        = ptr_q < count_q;
  assign step          = cmd_i.scan_step | cmd_i.shift_step;
  assign pos_idx       = IdxW'(item_q.position);
  assign last_idx      = IdxW'(count_q - 1'b1);
  assign count_w32     = 32'(count_q);
  assign cmp_w32       = 32'(cmp_idx_q);
  assign count_wide    = WideW'(count_q);
  assign res_key_wide  = 64'(res_key_q);

  assign sts_o.mode      = item_q.mode;
  assign sts_o.strategy  = strat_q;
  assign sts_o.pos_ok    = WideW'(item_q.position) < count_wide;
  assign sts_o.match     = rdv_q && (rd_key == item_key);
  assign sts_o.scan_done = !rdv_q && !ptr_lt;

  assign out_word_o = out_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[IdxW-1:0];
    if (step && ptr_lt) begin
      rd_en = 1'b1;
    end
    if (cmd_i.read_pos) begin
      rd_en   = 1'b1;
      rd_addr = pos_idx;
    end
    if (cmd_i.move_rd) begin
      rd_en   = 1'b1;
      rd_addr = last_idx;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx_q - 1'b1;
    wr_data = rd_q;
    if (cmd_i.append && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IdxW-1:0];
      wr_data = {item_key, item_q.payload};
    end else if (cmd_i.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = found_idx_q;
    end else if (cmd_i.shift_step && rdv_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append && !full) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.dec_count) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    rdv_d = rdv_q;
    if (cmd_i.scan_init) begin
      ptr_d = '0;
      rdv_d = 1'b0;
    end else if (cmd_i.shift_init) begin
      ptr_d = CntW'(cmp_idx_q) + 1'b1;
      rdv_d = 1'b0;
    end else if (step) begin
      rdv_d = ptr_lt;
      if (ptr_lt) begin
        ptr_d = ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      rdv_q   <= 1'b0;
      cap_q   <= klt_pkg::CAP_RESET;
      strat_q <= klt_pkg::STRAT_RESET;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      rdv_q   <= rdv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          klt_pkg::REG_CAPACITY: cap_q   <= cfg_data_i;
          klt_pkg::REG_STRATEGY: strat_q <= cfg_data_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (step) begin
      cmp_idx_q <= ptr_q[IdxW-1:0];
    end
    if (cmd_i.cap_hit) begin
      found_idx_q <= cmp_idx_q;
    end
    if (cmd_i.append) begin
      if (full) begin
        res_status_q <= klt_pkg::ST_FULL;
        res_pos_q    <= '0;
        res_key_q    <= '0;
        res_pay_q    <= '0;
      end else begin
        res_status_q <= klt_pkg::ST_OK;
        res_pos_q    <= count_w32[klt_pkg::POS_W-1:0];
        res_key_q    <= item_key;
        res_pay_q    <= item_q.payload;
      end
    end
    if (cmd_i.res_empty) begin
      res_status_q <= klt_pkg::ST_EMPTY;
      res_pos_q    <= item_q.position;
      res_key_q    <= '0;
      res_pay_q    <= '0;
    end
    if (cmd_i.cap_read) begin
      res_status_q <= klt_pkg::ST_OK;
      res_pos_q    <= item_q.position;
      res_key_q    <= rd_key;
      res_pay_q    <= rd_pay;
    end
    if (cmd_i.cap_hit) begin
      res_status_q <= klt_pkg::ST_OK;
      res_pos_q    <= cmp_w32[klt_pkg::POS_W-1:0];
      res_key_q    <= rd_key;
      res_pay_q    <= rd_pay;
    end
    if (cmd_i.res_miss) begin
      res_status_q <= klt_pkg::ST_NOT_FOUND;
      res_pos_q    <= '0;
      res_key_q    <= '0;
      res_pay_q    <= '0;
    end
    if (cmd_i.out_load) begin
      out_q.status         <= res_status_q;
      out_q.found_position <= res_pos_q;
      out_q.found_key      <= res_key_wide[klt_pkg::KEY_W-1:0];
      out_q.found_payload  <= res_pay_q;
      out_q.entry_count    <= count_wide[klt_pkg::CNT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/klt_ctrl.sv =====
module klt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  klt_pkg::sts_t sts_i,
  output klt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.mode)
          klt_pkg::MODE_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = S_DONE;
          end
          klt_pkg::MODE_LOOKUP, klt_pkg::MODE_REMOVE: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SEARCH;
          end
          klt_pkg::MODE_READ: begin
            if (sts_i.pos_ok) begin
              cmd_o.read_pos = 1'b1;
              state_d        = S_READ;
            end else begin
              cmd_o.res_empty = 1'b1;
              state_d         = S_DONE;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_DONE;
      end
      S_SEARCH: begin
        if (sts_i.match) begin
          cmd_o.cap_hit = 1'b1;
          if (sts_i.mode == klt_pkg::MODE_REMOVE) begin
            if (sts_i.strategy) begin
              cmd_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end else begin
              cmd_o.move_rd = 1'b1;
              state_d       = S_MOVE;
            end
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.scan_done) begin
          cmd_o.res_miss = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MOVE: begin
        cmd_o.move_wr   = 1'b1;
        cmd_o.dec_count = 1'b1;
        state_d         = S_DONE;
      end
      S_SHIFT: begin
        if (sts_i.scan_done) begin
          cmd_o.dec_count = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/klt_checker.sv =====
module klt_checker #(
  parameter int MAX_ENTRIES = 32
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input klt_pkg::out_word_t out_word_i
);

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i.status != klt_pkg::ST_OK) |->
      (out_word_i.found_key == '0) && (out_word_i.found_payload == '0))
    else $error("error result carries nonzero key or payload");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_word_i.status == klt_pkg::ST_FULL) ||
                    (out_word_i.status == klt_pkg::ST_NOT_FOUND)) |->
      (out_word_i.found_position == '0))
    else $error("full or miss result carries nonzero position");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(out_word_i.entry_count) <= MAX_ENTRIES))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled output word changed");

endmodule

bind keyed_list_table_top klt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_klt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH          = 32;
  localparam int SETTLE         = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  klt_pkg::in_word_t         in_word;
  logic                      out_valid;
  logic                      out_ready;
  klt_pkg::out_word_t        out_word;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [klt_pkg::CFG_W-1:0] cfg_data;

  // table shadow
  logic [klt_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [klt_pkg::PAY_W-1:0] pay_mem [DEPTH];
  int                        fill_cnt;
  logic [klt_pkg::CFG_W-1:0] cap_reg;
  logic                      strat_reg;

  klt_pkg::out_word_t        pending_results [$];
  logic [klt_pkg::KEY_W-1:0] key_pool [8];
  int                        error_cnt = 0;
  int                        quiet_cycles = 0;
  int                        stall_left = 0;
  int                        hold_left = 0;
  bit                        hold_req = 1'b0;
  bit                        no_idle = 1'b0;

  keyed_list_table_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int cap_in_use();
    return (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
  endfunction

  function automatic klt_pkg::out_word_t apply_command(klt_pkg::in_word_t w);
    klt_pkg::out_word_t r;
    int                 idx;
    int                 i;
    r = '0;
    r.status = klt_pkg::ST_OK;
    idx = -1;
    case (w.mode)
      klt_pkg::MODE_APPEND: begin
        if (fill_cnt < cap_in_use()) begin
          key_mem[fill_cnt] = w.key;
          pay_mem[fill_cnt] = w.payload;
          r.found_position = klt_pkg::POS_W'(fill_cnt);
          r.found_key = w.key;
          r.found_payload = w.payload;
          fill_cnt++;
        end else begin
          r.status = klt_pkg::ST_FULL;
        end
      end
      klt_pkg::MODE_LOOKUP, klt_pkg::MODE_REMOVE: begin
        for (i = fill_cnt - 1; i >= 0; i--) begin
          if (key_mem[i] == w.key) idx = i;
        end
        if (idx < 0) begin
          r.status = klt_pkg::ST_NOT_FOUND;
        end else begin
          r.found_position = klt_pkg::POS_W'(idx);
          r.found_key = key_mem[idx];
          r.found_payload = pay_mem[idx];
          if (w.mode == klt_pkg::MODE_REMOVE) begin
            if (strat_reg == 1'b0) begin
              key_mem[idx] = key_mem[fill_cnt-1];
              pay_mem[idx] = pay_mem[fill_cnt-1];
            end else begin
              for (i = idx; i < fill_cnt - 1; i++) begin
                key_mem[i] = key_mem[i+1];
                pay_mem[i] = pay_mem[i+1];
              end
            end
            fill_cnt--;
          end
        end
      end
      klt_pkg::MODE_READ: begin
        r.found_position = w.position;
        if (w.position < fill_cnt) begin
          r.found_key = key_mem[w.position];
          r.found_payload = pay_mem[w.position];
        end else begin
          r.status = klt_pkg::ST_EMPTY;
        end
      end
    endcase
    r.entry_count = klt_pkg::CNT_W'(fill_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_cnt++;
    $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result(klt_pkg::out_word_t got);
    klt_pkg::out_word_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending", got.found_payload, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.found_position !== want.found_position)
      report_mismatch("found_position", got.found_position, want.found_position);
    if (got.found_key !== want.found_key)
      report_mismatch("found_key", got.found_key, want.found_key);
    if (got.found_payload !== want.found_payload)
      report_mismatch("found_payload", got.found_payload, want.found_payload);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", got.entry_count, want.entry_count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      stall_left <= no_idle ? 0 : $urandom_range(0, 6);
      check_result(out_word);
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(klt_pkg::in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(apply_command(w));
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [klt_pkg::CFG_W-1:0] val);
    wait_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == klt_pkg::REG_CAPACITY) cap_reg = val;
    else strat_reg = val[0];
  endtask

  function automatic klt_pkg::in_word_t make_word(logic [klt_pkg::MODE_W-1:0] m,
                                                  logic [klt_pkg::KEY_W-1:0] k,
                                                  logic [klt_pkg::PAY_W-1:0] p,
                                                  logic [klt_pkg::POS_W-1:0] pos);
    klt_pkg::in_word_t w;
    w.mode = m;
    w.key = k;
    w.payload = p;
    w.position = pos;
    return w;
  endfunction

  function automatic logic [klt_pkg::PAY_W-1:0] rand_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // mostly keys that are in the table, so lookups and removes hit
  function automatic logic [klt_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (fill_cnt > 0 && r < 70) return key_mem[$urandom_range(0, fill_cnt - 1)];
    if (r < 85) return key_pool[$urandom_range(0, 7)];
    return klt_pkg::KEY_W'($urandom());
  endfunction

  task automatic issue_op(logic [klt_pkg::MODE_W-1:0] mode);
    klt_pkg::in_word_t w;
    w = make_word(mode, '0, rand_payload(), klt_pkg::POS_W'($urandom()));
    if (mode == klt_pkg::MODE_APPEND)
      w.key = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)]
                                          : klt_pkg::KEY_W'($urandom());
    else
      w.key = pick_key();
    if (mode == klt_pkg::MODE_READ && $urandom_range(0, 9) < 7)
      w.position = klt_pkg::POS_W'($urandom_range(0, fill_cnt));
    send_word(w);
  endtask

  task automatic test_directed();
    send_word(make_word(klt_pkg::MODE_READ,   '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_LOOKUP, 31'd5, '0, '0));
    send_word(make_word(klt_pkg::MODE_REMOVE, 31'd5, '0, '0));
    send_word(make_word(klt_pkg::MODE_APPEND, '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_APPEND, '1, '1, '1));
    send_word(make_word(klt_pkg::MODE_APPEND, '0, 64'hA5A5_A5A5_A5A5_A5A5, '0));
    send_word(make_word(klt_pkg::MODE_APPEND, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555,
                        '0));
    send_word(make_word(klt_pkg::MODE_LOOKUP, '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_READ,   '0, '0, '1));
    send_word(make_word(klt_pkg::MODE_READ,   '0, '0, 5'd2));
    send_word(make_word(klt_pkg::MODE_REMOVE, '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_READ,   '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_LOOKUP, '0, '0, '0));
    send_word(make_word(klt_pkg::MODE_LOOKUP, 31'h1234_5678, '1, '0));
    send_word(make_word(klt_pkg::MODE_READ,   '1, '1, 5'd3));
  endtask

  task automatic test_capacity_rules();
    write_reg(klt_pkg::REG_CAPACITY, '0);
    send_word(make_word(klt_pkg::MODE_APPEND, 31'd9, '1, '0));
    send_word(make_word(klt_pkg::MODE_READ,   '0, '0, 5'd1));
    send_word(make_word(klt_pkg::MODE_LOOKUP, '1, '0, '0));
    // limit below the current count: entries stay, appends refused
    write_reg(klt_pkg::REG_CAPACITY, 6'd2);
    send_word(make_word(klt_pkg::MODE_APPEND, 31'd9, '1, '0));
    send_word(make_word(klt_pkg::MODE_REMOVE, '1, '0, '0));
    send_word(make_word(klt_pkg::MODE_APPEND, 31'd9, '1, '0));
    send_word(make_word(klt_pkg::MODE_REMOVE, 31'h2AAA_AAAA, '0, '0));
    send_word(make_word(klt_pkg::MODE_APPEND, 31'd1, 64'h0123_4567_89AB_CDEF, '0));
  endtask

  task automatic test_fill_drain();
    int r;
    while (fill_cnt < cap_in_use()) issue_op(klt_pkg::MODE_APPEND);
    issue_op(klt_pkg::MODE_APPEND);
    while (fill_cnt > 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) issue_op(klt_pkg::MODE_REMOVE);
      else if (r < 80) issue_op(klt_pkg::MODE_LOOKUP);
      else issue_op(klt_pkg::MODE_READ);
    end
  endtask

  task automatic test_backpressure();
    wait_results();
    hold_req = 1'b1;
    repeat (12) issue_op(klt_pkg::MODE_W'($urandom()));
    wait_results();
  endtask

  task automatic test_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) wait_results();
      r = $urandom_range(0, 99);
      if (r < 35) issue_op(klt_pkg::MODE_APPEND);
      else if (r < 58) issue_op(klt_pkg::MODE_LOOKUP);
      else if (r < 80) issue_op(klt_pkg::MODE_REMOVE);
      else issue_op(klt_pkg::MODE_READ);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = 1'b0;
    cfg_data  = '0;
    fill_cnt  = 0;
    cap_reg   = klt_pkg::CAP_RESET;
    strat_reg = klt_pkg::STRAT_RESET;
    foreach (key_pool[i]) key_pool[i] = klt_pkg::KEY_W'($urandom());
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity_rules();
    write_reg(klt_pkg::REG_CAPACITY, 6'd32);
    write_reg(klt_pkg::REG_STRATEGY, 6'd0);
    test_fill_drain();
    write_reg(klt_pkg::REG_STRATEGY, 6'd1);
    test_fill_drain();
    test_backpressure();
    write_reg(klt_pkg::REG_CAPACITY, 6'd1);
    write_reg(klt_pkg::REG_STRATEGY, 6'd0);
    test_mix(60);
    write_reg(klt_pkg::REG_CAPACITY, '1);
    write_reg(klt_pkg::REG_STRATEGY, 6'd1);
    test_mix(100);
    repeat (3) begin
      write_reg(klt_pkg::REG_CAPACITY, klt_pkg::CFG_W'($urandom_range(2, 31)));
      write_reg(klt_pkg::REG_STRATEGY, klt_pkg::CFG_W'($urandom_range(0, 1)));
      test_mix(100);
    end

    wait_results();
    repeat (SETTLE) @(negedge clk);
    if (error_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
